// File: hdl/zsn_pkg.sv
// shared types, constants and state encodings of the z-score normalizer
package zsn_pkg;

    localparam int NUM_CHANNELS_DEF = 17;
    localparam int RING_DEPTH_DEF   = 32768;

    localparam int CH_FIELD_W = 5;
    localparam int X_W        = 24;
    localparam int Z_W        = 24;
    localparam int LEN_W      = 16;
    localparam int SUM_W      = 39;
    localparam int SQ_W       = 62;

    localparam logic [LEN_W-1:0] LONG_LEN_RESET  = 16'd20000;
    localparam logic [LEN_W-1:0] SHORT_LEN_RESET = 16'd1500;

    localparam logic [Z_W-1:0] Z_POS_MAX = 24'h7FFFFF;
    localparam logic [Z_W-1:0] Z_NEG_MAG = 24'h800000;

    // register index, taken from paddr[2]
    localparam logic REG_LONG_LEN  = 1'b0;
    localparam logic REG_SHORT_LEN = 1'b1;

    // request kinds on tuser
    localparam logic REQ_ADD  = 1'b0;
    localparam logic REQ_NORM = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_LONG,
        ST_RD_SHORT,
        ST_SQ_LONG,
        ST_SQ_SHORT,
        ST_SQ_NEW,
        ST_WRITE,
        ST_NORM_LONG,
        ST_WAIT_LONG,
        ST_NORM_SHORT,
        ST_WAIT_SHORT,
        ST_OUT
    } top_state_t;

    typedef enum logic [3:0] {
        SC_IDLE,
        SC_MUL,
        SC_ACC,
        SC_CMP,
        SC_SQRT,
        SC_NUM,
        SC_DIVCHK,
        SC_DIV,
        SC_DONE
    } score_state_t;

    typedef struct packed {
        logic           done;
        logic           valid;
        logic [Z_W-1:0] z;
    } score_res_t;

endpackage

// File: hdl/zsn_score.sv
// iterative score unit: shared multiplier, bit-pair square root and restoring divider
module zsn_score
    import zsn_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF,
    localparam int FC_W = $clog2(RING_DEPTH + 1)
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [SUM_W-1:0] sum,
    input  logic [SQ_W-1:0]         sq,
    input  logic [FC_W-1:0]         n,
    input  logic signed [X_W-1:0]   x,
    output score_res_t              res
);

    score_state_t state_reg, state_next;

    logic [2:0]         op_reg;
    logic [63:0]        prod_reg;
    logic [79:0]        nq_reg;
    logic [79:0]        ss_reg;
    logic [39:0]        nx_reg;
    logic [79:0]        v_reg;
    logic [41:0]        rem_reg;
    logic [39:0]        root_reg;
    logic [5:0]         cnt_reg;
    logic signed [40:0] d_reg;
    logic [57:0]        num_reg;
    logic [23:0]        nlow_reg;
    logic [40:0]        drem_reg;
    logic [Z_W-1:0]     quo_reg;
    logic               sat_reg;
    logic               dneg_reg;
    logic               inval_reg;
    score_res_t         res_reg;

    logic [SUM_W-1:0] abs_sum;
    logic [X_W-1:0]   abs_x;
    logic [31:0]      mul_a;
    logic [31:0]      mul_b;
    logic [43:0]      sqrt_t;
    logic [43:0]      sqrt_trial;
    logic [40:0]      den;
    logic [41:0]      div_t;
    logic [39:0]      abs_d;
    logic [Z_W-1:0]   mag;
    logic [Z_W-1:0]   z_calc;

    assign abs_sum = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
    assign abs_x   = x[X_W-1] ? X_W'(-x) : X_W'(x);
    assign den     = {root_reg, 1'b0};
    assign sqrt_t  = {rem_reg, v_reg[79:78]};
    assign sqrt_trial = {2'b00, root_reg, 2'b01};
    assign div_t   = {drem_reg, nlow_reg[23]};
    assign abs_d   = d_reg[40] ? 40'(-d_reg) : 40'(d_reg);

    // operand selection for the shared multiplier
    always_comb
    begin
        case (op_reg)
            3'd0:
            begin
                mul_a = 32'(n);
                mul_b = {1'b0, sq[30:0]};
            end
            3'd1:
            begin
                mul_a = 32'(n);
                mul_b = {1'b0, sq[61:31]};
            end
            3'd2:
            begin
                mul_a = 32'(abs_sum[19:0]);
                mul_b = 32'(abs_sum[19:0]);
            end
            3'd3:
            begin
                mul_a = 32'(abs_sum[19:0]);
                mul_b = 32'(abs_sum[38:20]);
            end
            3'd4:
            begin
                mul_a = 32'(abs_sum[38:20]);
                mul_b = 32'(abs_sum[38:20]);
            end
            default:
            begin
                mul_a = 32'(n);
                mul_b = 32'(abs_x);
            end
        endcase
    end

    always_comb
    begin
        if (dneg_reg)
        begin
            mag    = (sat_reg || quo_reg > Z_NEG_MAG) ? Z_NEG_MAG : quo_reg;
            z_calc = Z_W'(~mag + 1'b1);
        end
        else
        begin
            mag    = quo_reg;
            z_calc = (sat_reg || quo_reg[Z_W-1]) ? Z_POS_MAX : quo_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            SC_IDLE:
            begin
                if (start)
                begin
                    state_next = (n == '0) ? SC_DONE : SC_MUL;
                end
            end
            SC_MUL:
            begin
                state_next = SC_ACC;
            end
            SC_ACC:
            begin
                state_next = (op_reg == 3'd5) ? SC_CMP : SC_MUL;
            end
            SC_CMP:
            begin
                state_next = (nq_reg <= ss_reg) ? SC_DONE : SC_SQRT;
            end
            SC_SQRT:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = SC_NUM;
                end
            end
            SC_NUM:
            begin
                state_next = SC_DIVCHK;
            end
            SC_DIVCHK:
            begin
                state_next = ({7'b0, num_reg} >= {den, 24'b0}) ? SC_DONE : SC_DIV;
            end
            SC_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = SC_DONE;
                end
            end
            SC_DONE:
            begin
                state_next = SC_IDLE;
            end
            default:
            begin
                state_next = SC_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SC_IDLE;
            res_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            res_reg.done  <= (state_reg == SC_DONE);
            res_reg.valid <= (state_reg == SC_DONE) && !inval_reg;
            res_reg.z     <= (state_reg == SC_DONE && !inval_reg) ? z_calc : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            SC_IDLE:
            begin
                op_reg    <= '0;
                inval_reg <= (n == '0);
                sat_reg   <= 1'b0;
                dneg_reg  <= 1'b0;
                quo_reg   <= '0;
            end
            SC_MUL:
            begin
                prod_reg <= mul_a * mul_b;
            end
            SC_ACC:
            begin
                case (op_reg)
                    3'd0: nq_reg <= 80'(prod_reg);
                    3'd1: nq_reg <= nq_reg + (80'(prod_reg) << 31);
                    3'd2: ss_reg <= 80'(prod_reg);
                    3'd3: ss_reg <= ss_reg + (80'(prod_reg) << 21);
                    3'd4: ss_reg <= ss_reg + (80'(prod_reg) << 40);
                    default: nx_reg <= prod_reg[39:0];
                endcase
                op_reg <= op_reg + 3'd1;
            end
            SC_CMP:
            begin
                inval_reg <= (nq_reg <= ss_reg);
                v_reg     <= nq_reg - ss_reg;
                rem_reg   <= '0;
                root_reg  <= '0;
                cnt_reg   <= 6'd39;
                d_reg     <= (x[X_W-1] ? -$signed({1'b0, nx_reg}) : $signed({1'b0, nx_reg}))
                             - 41'(sum);
            end
            SC_SQRT:
            begin
                // one root bit per step from the top pair of the radicand
                if (sqrt_t >= sqrt_trial)
                begin
                    rem_reg  <= 42'(sqrt_t - sqrt_trial);
                    root_reg <= {root_reg[38:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= sqrt_t[41:0];
                    root_reg <= {root_reg[38:0], 1'b0};
                end
                v_reg   <= {v_reg[77:0], 2'b00};
                cnt_reg <= cnt_reg - 6'd1;
            end
            SC_NUM:
            begin
                dneg_reg <= d_reg[40];
                num_reg  <= (58'(abs_d) << 17) + 58'(root_reg);
            end
            SC_DIVCHK:
            begin
                sat_reg  <= ({7'b0, num_reg} >= {den, 24'b0});
                drem_reg <= 41'(num_reg[57:24]);
                nlow_reg <= num_reg[23:0];
                quo_reg  <= '0;
                cnt_reg  <= 6'd23;
            end
            SC_DIV:
            begin
                if (div_t >= {1'b0, den})
                begin
                    drem_reg <= 41'(div_t - {1'b0, den});
                    quo_reg  <= {quo_reg[Z_W-2:0], 1'b1};
                end
                else
                begin
                    drem_reg <= div_t[40:0];
                    quo_reg  <= {quo_reg[Z_W-2:0], 1'b0};
                end
                nlow_reg <= {nlow_reg[22:0], 1'b0};
                cnt_reg  <= cnt_reg - 6'd1;
            end
            default:
            begin
            end
        endcase
    end

    assign res = res_reg;

`ifndef SYNTHESIS
    a_valid_root: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == SC_DONE && !inval_reg) |-> (root_reg != '0))
        else $error("score valid with zero root");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        res_reg.done |=> !res_reg.done)
        else $error("score done longer than one cycle");
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_reg.done && !res_reg.valid) |-> (res_reg.z == '0))
        else $error("invalid score not zero");
`endif

endmodule

// File: hdl/dual_window_zscore_normalizer.sv
// top level: per-channel sample rings, window sums and request sequencer
//
// Input stream: s_axis_tuser is the request kind (add a sample or normalize
// a value), s_axis_tdata carries channel and Q8.16 value. An add transfer
// stores the sample and updates the long and short window sums, evicting
// the samples that leave each window; it produces no output. A normalize
// transfer produces one output transfer with both z-scores and valid flags.
// Each request runs to completion before the next is taken: the score unit
// runs once per window through the shared multiplier, then, for a non-zero
// variance, 40 square root steps and 24 divide steps. An out-of-range channel
// is ignored on add and answered with zero scores on normalize. s_axis_tready
// is high only while the sequencer is idle.
// The result sits in an output register; a new input is taken while it waits,
// and a later normalize holds in its final state until the register drains.
// Reset (and any register write over APB) empties all windows; the window
// length registers return to 20000 and 1500 on reset. Ring contents are not
// cleared: only entries already written are ever read.
module dual_window_zscore_normalizer
    import zsn_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
    parameter int RING_DEPTH   = RING_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // channel[4:0], sample_value[28:5]
    input  logic        s_axis_tuser,  // req_type[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // result_channel[4:0], z_long[28:5], z_short[52:29], long_valid[53], short_valid[54]
    output logic [55:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int SLOT_W = $clog2(RING_DEPTH);
    localparam int FC_W   = $clog2(RING_DEPTH + 1);

    top_state_t state_reg, state_next;

    logic [LEN_W-1:0] long_len_reg;
    logic [LEN_W-1:0] short_len_reg;

    logic [SLOT_W-1:0]       wslot_reg [NUM_CHANNELS];
    logic [FC_W-1:0]         fill_reg  [NUM_CHANNELS];
    logic signed [SUM_W-1:0] lsum_reg  [NUM_CHANNELS];
    logic [SQ_W-1:0]         lsq_reg   [NUM_CHANNELS];
    logic signed [SUM_W-1:0] ssum_reg  [NUM_CHANNELS];
    logic [SQ_W-1:0]         ssq_reg   [NUM_CHANNELS];

    logic signed [X_W-1:0] ring_mem [NUM_CHANNELS][RING_DEPTH];

    logic                   type_reg;
    logic [CH_FIELD_W-1:0]  ch_reg;
    logic                   ch_ok_reg;
    logic signed [X_W-1:0]  x_reg;
    logic signed [X_W-1:0]  rd_data_reg;
    logic signed [X_W-1:0]  old_l_reg;
    logic signed [X_W-1:0]  old_s_reg;
    logic [2*X_W-1:0]       sq_reg;
    logic [Z_W-1:0]         zl_reg;
    logic [Z_W-1:0]         zs_reg;
    logic                   lv_reg;
    logic                   sv_reg;
    logic                   out_valid_reg, out_valid_next;
    logic [55:0]            out_data_reg;

    logic                  in_xfer;
    logic                  cfg_wr;
    logic                  ch_ok_in;
    logic [CH_W-1:0]       chi;
    logic [FC_W-1:0]       ll;
    logic [FC_W-1:0]       sl;
    logic [FC_W-1:0]       fc;
    logic [SLOT_W-1:0]     ws;
    logic                  evl;
    logic                  evs;
    logic [FC_W:0]         tl;
    logic [FC_W:0]         ts;
    logic [SLOT_W-1:0]     ev_l_addr;
    logic [SLOT_W-1:0]     ev_s_addr;
    logic                  rd_en;
    logic [SLOT_W-1:0]     rd_addr;
    logic                  wr_en;
    logic                  out_load;
    logic                  sc_start;
    logic                  sc_short;
    logic signed [X_W-1:0] sq_op;
    logic signed [2*X_W-1:0] sq_prod;
    logic [FC_W-1:0]       n_long;
    logic [FC_W-1:0]       n_short;
    score_res_t            sc_res;

    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign ch_ok_in = ({1'b0, s_axis_tdata[4:0]} < 6'(NUM_CHANNELS));
    assign chi      = ch_reg[CH_W-1:0];
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_SHORT_LEN) ? {16'b0, short_len_reg}
                                                  : {16'b0, long_len_reg};

    // effective window lengths, clamped to 1..RING_DEPTH
    always_comb
    begin
        if (long_len_reg == '0)
            ll = FC_W'(1);
        else if ({1'b0, long_len_reg} > 17'(RING_DEPTH))
            ll = FC_W'(RING_DEPTH);
        else
            ll = long_len_reg[FC_W-1:0];
        if (short_len_reg == '0)
            sl = FC_W'(1);
        else if ({1'b0, short_len_reg} > 17'(RING_DEPTH))
            sl = FC_W'(RING_DEPTH);
        else
            sl = short_len_reg[FC_W-1:0];
    end

    assign fc  = fill_reg[chi];
    assign ws  = wslot_reg[chi];
    assign evl = (fc >= ll);
    assign evs = (fc >= sl);
    assign n_long  = (fc < ll) ? fc : ll;
    assign n_short = (fc < sl) ? fc : sl;

    // slot that leaves each window, modulo the ring depth
    assign tl = (FC_W+1)'(ws) + (FC_W+1)'(RING_DEPTH) - (FC_W+1)'(ll);
    assign ts = (FC_W+1)'(ws) + (FC_W+1)'(RING_DEPTH) - (FC_W+1)'(sl);
    assign ev_l_addr = (tl >= (FC_W+1)'(RING_DEPTH)) ? SLOT_W'(tl - (FC_W+1)'(RING_DEPTH))
                                                     : SLOT_W'(tl);
    assign ev_s_addr = (ts >= (FC_W+1)'(RING_DEPTH)) ? SLOT_W'(ts - (FC_W+1)'(RING_DEPTH))
                                                     : SLOT_W'(ts);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (s_axis_tuser == REQ_ADD)
                        state_next = ch_ok_in ? ST_RD_LONG : ST_IDLE;
                    else
                        state_next = ch_ok_in ? ST_NORM_LONG : ST_OUT;
                end
            end
            ST_RD_LONG:    state_next = ST_RD_SHORT;
            ST_RD_SHORT:   state_next = ST_SQ_LONG;
            ST_SQ_LONG:    state_next = ST_SQ_SHORT;
            ST_SQ_SHORT:   state_next = ST_SQ_NEW;
            ST_SQ_NEW:     state_next = ST_WRITE;
            ST_WRITE:      state_next = ST_IDLE;
            ST_NORM_LONG:  state_next = ST_WAIT_LONG;
            ST_WAIT_LONG:  state_next = sc_res.done ? ST_NORM_SHORT : ST_WAIT_LONG;
            ST_NORM_SHORT: state_next = ST_WAIT_SHORT;
            ST_WAIT_SHORT: state_next = sc_res.done ? ST_OUT : ST_WAIT_SHORT;
            ST_OUT:        state_next = (!out_valid_reg || m_axis_tready) ? ST_IDLE : ST_OUT;
            default:       state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_axis_tready = 1'b0;
        rd_en    = 1'b0;
        rd_addr  = ev_l_addr;
        wr_en    = 1'b0;
        sc_start = 1'b0;
        sc_short = 1'b0;
        out_load = 1'b0;
        sq_op    = x_reg;
        unique case (state_reg)
            ST_IDLE:       s_axis_tready = 1'b1;
            ST_RD_LONG:    rd_en = 1'b1;
            ST_RD_SHORT:
            begin
                rd_en   = 1'b1;
                rd_addr = ev_s_addr;
            end
            ST_SQ_LONG:    sq_op = old_l_reg;
            ST_SQ_SHORT:   sq_op = old_s_reg;
            ST_SQ_NEW:     sq_op = x_reg;
            ST_WRITE:      wr_en = 1'b1;
            ST_NORM_LONG:  sc_start = 1'b1;
            ST_WAIT_LONG:  sc_short = 1'b0;
            ST_NORM_SHORT:
            begin
                sc_start = 1'b1;
                sc_short = 1'b1;
            end
            ST_WAIT_SHORT: sc_short = 1'b1;
            ST_OUT:        out_load = !out_valid_reg || m_axis_tready;
            default:       s_axis_tready = 1'b0;
        endcase
    end

    assign sq_prod = sq_op * sq_op;

    zsn_score #(
        .RING_DEPTH (RING_DEPTH)
    ) u_score (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sc_start),
        .sum   (sc_short ? ssum_reg[chi] : lsum_reg[chi]),
        .sq    (sc_short ? ssq_reg[chi] : lsq_reg[chi]),
        .n     (sc_short ? n_short : n_long),
        .x     (x_reg),
        .res   (sc_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            long_len_reg  <= LONG_LEN_RESET;
            short_len_reg <= SHORT_LEN_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr)
            begin
                if (paddr[2] == REG_LONG_LEN)
                    long_len_reg <= pwdata[LEN_W-1:0];
                else
                    short_len_reg <= pwdata[LEN_W-1:0];
            end
        end
    end

    assign out_valid_next = out_load ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_reg);

    // per-channel window state; any register write empties every channel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                wslot_reg[i] <= '0;
                fill_reg[i]  <= '0;
                lsum_reg[i]  <= '0;
                lsq_reg[i]   <= '0;
                ssum_reg[i]  <= '0;
                ssq_reg[i]   <= '0;
            end
        end
        else if (cfg_wr)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                wslot_reg[i] <= '0;
                fill_reg[i]  <= '0;
                lsum_reg[i]  <= '0;
                lsq_reg[i]   <= '0;
                ssum_reg[i]  <= '0;
                ssq_reg[i]   <= '0;
            end
        end
        else
        begin
            case (state_reg)
                ST_SQ_SHORT:
                begin
                    if (evl)
                    begin
                        lsum_reg[chi] <= lsum_reg[chi] - SUM_W'(old_l_reg);
                        lsq_reg[chi]  <= lsq_reg[chi] - SQ_W'(sq_reg);
                    end
                end
                ST_SQ_NEW:
                begin
                    if (evs)
                    begin
                        ssum_reg[chi] <= ssum_reg[chi] - SUM_W'(old_s_reg);
                        ssq_reg[chi]  <= ssq_reg[chi] - SQ_W'(sq_reg);
                    end
                end
                ST_WRITE:
                begin
                    lsum_reg[chi] <= lsum_reg[chi] + SUM_W'(x_reg);
                    lsq_reg[chi]  <= lsq_reg[chi] + SQ_W'(sq_reg);
                    ssum_reg[chi] <= ssum_reg[chi] + SUM_W'(x_reg);
                    ssq_reg[chi]  <= ssq_reg[chi] + SQ_W'(sq_reg);
                    wslot_reg[chi] <= (ws == SLOT_W'(RING_DEPTH - 1)) ? '0 : ws + 1'b1;
                    if (fc < FC_W'(RING_DEPTH))
                        fill_reg[chi] <= fc + 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= ring_mem[chi][rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            ring_mem[chi][ws] <= x_reg;
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            type_reg  <= s_axis_tuser;
            ch_reg    <= s_axis_tdata[4:0];
            ch_ok_reg <= ch_ok_in;
            x_reg     <= s_axis_tdata[28:5];
            zl_reg    <= '0;
            zs_reg    <= '0;
            lv_reg    <= 1'b0;
            sv_reg    <= 1'b0;
        end
        if (state_reg == ST_RD_SHORT)
            old_l_reg <= rd_data_reg;
        if (state_reg == ST_SQ_LONG)
            old_s_reg <= rd_data_reg;
        sq_reg <= unsigned'(sq_prod);
        if (state_reg == ST_WAIT_LONG && sc_res.done)
        begin
            zl_reg <= sc_res.z;
            lv_reg <= sc_res.valid;
        end
        if (state_reg == ST_WAIT_SHORT && sc_res.done)
        begin
            zs_reg <= sc_res.z;
            sv_reg <= sc_res.valid;
        end
        if (out_load)
            out_data_reg <= {1'b0, sv_reg, lv_reg, zs_reg, zl_reg, ch_reg};
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

`ifndef SYNTHESIS
    a_add_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && s_axis_tuser == REQ_ADD) |=> !$rose(m_axis_tvalid))
        else $error("add transfer produced a result");
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WRITE && ch_ok_reg) |-> (fc <= FC_W'(RING_DEPTH)))
        else $error("fill count beyond ring depth");
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tdata[53]) |-> (m_axis_tdata[28:5] == '0))
        else $error("invalid long score not zero");
    a_norm_type: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT) |-> (type_reg == REQ_NORM))
        else $error("result for an add request");
`endif

endmodule

// File: dv/dual_window_zscore_normalizer_tb.sv
// self-checking testbench of the dual-window z-score normalizer
module dual_window_zscore_normalizer_tb;
    import zsn_pkg::*;

    localparam int NCH        = NUM_CHANNELS_DEF;
    localparam int DEPTH      = RING_DEPTH_DEF;
    localparam int CYCLE_MAX  = 1000000;
    localparam int DRAIN_WAIT = 400;
    localparam int N_DIR      = 21;
    localparam int N_RAND     = 550;
    localparam int EXP_DEPTH  = 16;

    typedef struct packed {
        logic [4:0]  ch;
        logic [23:0] zl;
        logic [23:0] zs;
        logic        lv;
        logic        sv;
    } zres_t;

    typedef struct packed {
        logic        req;
        logic [4:0]  ch;
        logic [23:0] val;
        logic        typed;
        zres_t       res;
    } stim_row_t;

    // typed rows: empty windows, out-of-range channel, zero variance
    localparam stim_row_t DIR_TAB [N_DIR] = '{
        '{REQ_NORM, 5'd0,  24'h000000, 1'b1, '{5'd0,  24'h0, 24'h0, 1'b0, 1'b0}},
        '{REQ_NORM, 5'd16, 24'h7FFFFF, 1'b1, '{5'd16, 24'h0, 24'h0, 1'b0, 1'b0}},
        '{REQ_NORM, 5'd31, 24'h800000, 1'b1, '{5'd31, 24'h0, 24'h0, 1'b0, 1'b0}},
        '{REQ_ADD,  5'd20, 24'h123456, 1'b0, '0},
        '{REQ_ADD,  5'd0,  24'h800000, 1'b0, '0},
        '{REQ_NORM, 5'd0,  24'h800000, 1'b1, '{5'd0,  24'h0, 24'h0, 1'b0, 1'b0}},
        '{REQ_ADD,  5'd0,  24'h7FFFFF, 1'b0, '0},
        '{REQ_NORM, 5'd0,  24'h7FFFFF, 1'b0, '0},
        '{REQ_NORM, 5'd0,  24'h800000, 1'b0, '0},
        '{REQ_NORM, 5'd0,  24'h000000, 1'b0, '0},
        '{REQ_ADD,  5'd1,  24'h000005, 1'b0, '0},
        '{REQ_ADD,  5'd1,  24'h000005, 1'b0, '0},
        '{REQ_NORM, 5'd1,  24'h000005, 1'b1, '{5'd1,  24'h0, 24'h0, 1'b0, 1'b0}},
        '{REQ_ADD,  5'd2,  24'h000000, 1'b0, '0},
        '{REQ_ADD,  5'd2,  24'h000000, 1'b0, '0},
        '{REQ_ADD,  5'd2,  24'h000001, 1'b0, '0},
        '{REQ_NORM, 5'd2,  24'h7FFFFF, 1'b0, '0},
        '{REQ_NORM, 5'd2,  24'h800000, 1'b0, '0},
        '{REQ_ADD,  5'd16, 24'hFFFFFF, 1'b0, '0},
        '{REQ_ADD,  5'd16, 24'h555555, 1'b0, '0},
        '{REQ_NORM, 5'd16, 24'hAAAAAA, 1'b0, '0}
    };

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // channel[4:0], sample_value[28:5]
    logic        s_axis_tuser;   // req_type[0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // result_channel[4:0], z_long[28:5], z_short[52:29], long_valid[53], short_valid[54]
    logic [55:0] m_axis_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    dual_window_zscore_normalizer i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // predictor state
    int          ring [NCH][DEPTH];
    int          wr_slot [NCH];
    int          fill [NCH];
    longint      lsum [NCH];
    logic [63:0] lsq [NCH];
    longint      ssum [NCH];
    logic [63:0] ssq [NCH];
    logic [15:0] long_len_reg;
    logic [15:0] short_len_reg;

    // expected scores in order, counted in and out
    zres_t       exp_buf [EXP_DEPTH];
    int          exp_wr_cnt;
    int          exp_rd_cnt;
    int          mismatches;
    int          cycles;
    bit          calm;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_MAX)
        begin
            $display("dual_window_zscore_normalizer_tb: FAIL");
            $finish;
        end
    end

    always @(posedge clk)
        m_axis_tready <= calm || ($urandom_range(99) >= 35);

    function automatic void exp_store(input zres_t r);
        exp_buf[exp_wr_cnt % EXP_DEPTH] = r;
        exp_wr_cnt++;
    endfunction

    function automatic int clamp_len(input logic [15:0] r);
        if (r == 0)
            return 1;
        if (r > DEPTH)
            return DEPTH;
        return int'(r);
    endfunction

    function automatic void clear_windows();
        for (int c = 0; c < NCH; c++)
        begin
            wr_slot[c] = 0;
            fill[c]    = 0;
            lsum[c]    = 0;
            lsq[c]     = '0;
            ssum[c]    = 0;
            ssq[c]     = '0;
        end
    endfunction

    function automatic void window_score(input longint sum, input logic [63:0] sq,
                                         input int n, input longint x,
                                         output logic [23:0] z, output logic ok);
        logic [127:0] nq;
        logic [127:0] ss;
        logic [127:0] var_v;
        logic [127:0] root;
        logic [127:0] cand;
        logic [127:0] mag;
        logic [63:0]  abs_s;
        longint       dev;
        z  = '0;
        ok = 1'b0;
        if (n == 0)
            return;
        abs_s = (sum < 0) ? 64'(-sum) : 64'(sum);
        nq    = 128'(n) * 128'(sq);
        ss    = 128'(abs_s) * 128'(abs_s);
        if (nq <= ss)
            return;
        var_v = nq - ss;
        root  = '0;
        for (int b = 39; b >= 0; b--)
        begin
            cand = root | (128'd1 << b);
            if (cand * cand <= var_v)
                root = cand;
        end
        dev = longint'(n) * x - sum;
        mag = 128'((dev < 0) ? 64'(-dev) : 64'(dev)) << 16;
        mag = (2 * mag + root) / (2 * root);
        if (dev >= 0)
            z = (mag > 128'(Z_POS_MAX)) ? Z_POS_MAX : mag[23:0];
        else
        begin
            if (mag > 128'(Z_NEG_MAG))
                mag = 128'(Z_NEG_MAG);
            z = -mag[23:0];
        end
        ok = 1'b1;
    endfunction

    // applies one accepted request to the model, stores the score if any
    function automatic void apply_request(input logic req, input logic [4:0] ch,
                                          input logic [23:0] val);
        int     ll;
        int     sl;
        int     ws;
        int     fc;
        int     n;
        longint x;
        longint old;
        zres_t  r;
        ll = clamp_len(long_len_reg);
        sl = clamp_len(short_len_reg);
        x  = longint'(signed'(val));
        if (req == REQ_ADD)
        begin
            if (ch >= NCH)
                return;
            ws = wr_slot[ch];
            fc = fill[ch];
            if (fc >= ll)
            begin
                old = ring[ch][(ws + DEPTH - ll) % DEPTH];
                lsum[ch] -= old;
                lsq[ch]  -= 64'(old * old);
            end
            if (fc >= sl)
            begin
                old = ring[ch][(ws + DEPTH - sl) % DEPTH];
                ssum[ch] -= old;
                ssq[ch]  -= 64'(old * old);
            end
            ring[ch][ws] = int'(x);
            lsum[ch] += x;
            lsq[ch]  += 64'(x * x);
            ssum[ch] += x;
            ssq[ch]  += 64'(x * x);
            wr_slot[ch] = (ws + 1) % DEPTH;
            if (fc < DEPTH)
                fill[ch] = fc + 1;
            return;
        end
        r    = '0;
        r.ch = ch;
        if (ch < NCH)
        begin
            fc = fill[ch];
            n  = (fc < ll) ? fc : ll;
            window_score(lsum[ch], lsq[ch], n, x, r.zl, r.lv);
            n  = (fc < sl) ? fc : sl;
            window_score(ssum[ch], ssq[ch], n, x, r.zs, r.sv);
        end
        exp_store(r);
    endfunction

    always @(posedge clk)
    begin
        zres_t got;
        zres_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = '{m_axis_tdata[4:0], m_axis_tdata[28:5], m_axis_tdata[52:29],
                    m_axis_tdata[53], m_axis_tdata[54]};
            if (exp_wr_cnt == exp_rd_cnt)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer: ch %0d", got.ch);
            end
            else
            begin
                want = exp_buf[exp_rd_cnt % EXP_DEPTH];
                exp_rd_cnt++;
                if (got.ch != want.ch || got.zl != want.zl || got.zs != want.zs ||
                    got.lv != want.lv || got.sv != want.sv)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp ch %0d zl %h zs %h v %b%b,",
                                  " got ch %0d zl %h zs %h v %b%b"},
                                 want.ch, want.zl, want.zs, want.lv, want.sv,
                                 got.ch, got.zl, got.zs, got.lv, got.sv);
                end
            end
        end
    end

    task automatic send_item(input logic req, input logic [4:0] ch, input logic [23:0] val);
        while (!calm && $urandom_range(99) < 35)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= {3'b000, val, ch};
        do
            @(posedge clk);
        while (!(s_axis_tvalid && s_axis_tready));
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (exp_wr_cnt != exp_rd_cnt)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic reg_write(input logic idx, input logic [15:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'h0, val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx == REG_LONG_LEN)
            long_len_reg = val;
        else
            short_len_reg = val;
        clear_windows();
    endtask

    function automatic logic [23:0] pick_value();
        case ($urandom_range(4))
            0: return 24'($urandom);
            1: return 24'($urandom_range(16) - 8);
            2: return $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
            3: return 24'($urandom_range(4000) - 2000);
            default: return 24'($urandom_range(255) << 16);
        endcase
    endfunction

    initial
    begin
        logic [15:0] lens [5][2];
        logic        req;
        logic [4:0]  ch;
        lens = '{'{16'd20000, 16'd1500}, '{16'd32768, 16'd1}, '{16'd0, 16'd65535},
                 '{16'd7, 16'd3}, '{16'd40, 16'd12}};
        rst_n         = 1'b0;
        cycles        = 0;
        mismatches    = 0;
        exp_wr_cnt    = 0;
        exp_rd_cnt    = 0;
        calm          = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = REQ_ADD;
        m_axis_tready = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        long_len_reg  = LONG_LEN_RESET;
        short_len_reg = SHORT_LEN_RESET;
        clear_windows();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIR; i++)
        begin
            send_item(DIR_TAB[i].req, DIR_TAB[i].ch, DIR_TAB[i].val);
            if (DIR_TAB[i].typed)
                exp_store(DIR_TAB[i].res);
            else
                apply_request(DIR_TAB[i].req, DIR_TAB[i].ch, DIR_TAB[i].val);
        end

        for (int ph = 0; ph < 5; ph++)
        begin
            if (ph > 0)
            begin
                drain();
                reg_write(REG_LONG_LEN, lens[ph][0]);
                reg_write(REG_SHORT_LEN, lens[ph][1]);
            end
            calm = (ph == 3);
            for (int k = 0; k < N_RAND / 5; k++)
            begin
                // sender holds off once until every score is back
                if (ph == 2 && k == 50)
                    drain();
                req = ($urandom_range(99) < 70) ? REQ_ADD : REQ_NORM;
                ch  = ($urandom_range(15) == 0) ? 5'($urandom_range(31, NCH))
                                                : 5'($urandom_range(4));
                if ($urandom_range(3) == 0)
                    ch = 5'($urandom_range(NCH - 1));
                send_item(req, ch, pick_value());
                apply_request(req, ch, s_axis_tdata[28:5]);
            end
        end
        calm = 1'b0;
        drain();
        if (mismatches == 0)
            $display("dual_window_zscore_normalizer_tb: PASS");
        else
            $display("dual_window_zscore_normalizer_tb: FAIL");
        $finish;
    end

endmodule
